FILE: hdl/acf_pkg.sv
// ----------------------------------------------------------------------------
// acf_pkg
// Constants, register indexes and types for the actuator command framer.
// ----------------------------------------------------------------------------
package acf_pkg;

	localparam int unsigned FRAME_LEN  = 17;
	localparam int unsigned IDX_W      = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned S_DATA_W   = 56;

	localparam logic [7:0] SYNC0       = 8'hAA;
	localparam logic [7:0] SYNC1       = 8'h55;
	localparam logic [7:0] FRAME_SIZE  = 8'h0A;
	localparam logic [7:0] TYPE_DRIVE  = 8'hE0;
	localparam logic [7:0] TYPE_EXT    = 8'hE1;
	localparam logic [7:0] TYPE_SUFFIX = 8'h06;
	localparam logic [7:0] TAIL0       = 8'hBB;
	localparam logic [7:0] TAIL1       = 8'h66;
	localparam logic [7:0] EXT_FLAGS   = 8'h09;

	localparam logic [14:0] SEQ_WRAP      = 15'd32000;
	localparam logic [14:0] TORQUE_FULL   = 15'd32760;
	localparam logic [9:0]  THROTTLE_FULL = 10'd600;
	localparam logic [10:0] THROTTLE_BASE = 11'd200;

	localparam logic [7:0] GEAR_CHAR_D = 8'h44;
	localparam logic [7:0] GEAR_CHAR_R = 8'h52;
	localparam logic [7:0] GEAR_CHAR_N = 8'h4E;

	typedef enum logic [1:0] {
		GEAR_FWD     = 2'd0,
		GEAR_REV     = 2'd1,
		GEAR_NTRL    = 2'd2,
		GEAR_ILLEGAL = 2'd3
	} gear_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TORQUE_LIMIT   = 3'd0,
		REG_BRAKE_LIMIT    = 3'd1,
		REG_THROTTLE_LIMIT = 3'd2,
		REG_AUTONOMY_MASK  = 3'd3,
		REG_BELT_STEERING  = 3'd4,
		REG_STEER_ALLOWED  = 3'd5,
		REG_ENGINE_ALLOWED = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic              req_type;
		logic signed [15:0] steer_torque;
		logic [15:0]       brake_value;
		logic [9:0]        throttle_value;
		logic [1:0]        gear_code;
		logic [1:0]        blinker;
		logic              kill_req;
		logic              horn;
		logic              park_brake;
	} cmd_t;

	typedef logic [7:0] frame_t [FRAME_LEN];

endpackage

FILE: hdl/actuator_command_framer.sv
// ----------------------------------------------------------------------------
// actuator_command_framer
// Turns actuator commands into 17-byte serial frames, one byte per item out.
// ----------------------------------------------------------------------------
// Each accepted command yields a 17-byte frame (AA 55 0A, sequence counter
// low/high, type E0 06 or E1 06, eight payload bytes, BB 66) sent one byte
// per cycle while the output is ready, or a single error item when a drive
// command carries the illegal gear. With the output always ready, a frame
// follows the previous one without a gap. One command waits in the input
// register while the previous frame is still going out; the frame is built
// combinationally and registered as it enters the serializer. Configuration
// is written through cfg_we/cfg_index/cfg_data.
module actuator_command_framer
	import acf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// steer_torque, brake_value, throttle_value, gear_code, blinker,
	// kill_req, horn, park_brake, zero fill
	input  logic [S_DATA_W-1:0]    s_tdata,
	// req_type
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// frame_byte
	output logic [7:0]             m_tdata,
	output logic                   m_tlast,
	// gear_error
	output logic                   m_tuser
);

	// configuration
	logic [14:0] torque_limit_q;
	logic [15:0] brake_limit_q;
	logic [9:0]  throttle_limit_q;
	logic [3:0]  autonomy_mask_q;
	logic        belt_steering_q;
	logic        steer_allowed_q;
	logic        engine_allowed_q;

	// state
	logic [14:0]        seq_q;
	logic signed [15:0] held_torque_q;
	logic [15:0]        held_brake_q;
	logic [9:0]         held_throttle_q;

	// input register
	logic cmd_valid_s1;
	cmd_t cmd_s1;

	// serializer
	frame_t           frame_q;
	logic             busy_q;
	logic             err_q;
	logic [IDX_W-1:0] idx_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_err_q;

	logic out_free, out_load, ser_last, frame_load;

	assign out_free   = !out_valid_q || m_tready;
	assign out_load   = busy_q && out_free;
	assign ser_last   = err_q || (idx_q == IDX_W'(FRAME_LEN - 1));
	assign frame_load = cmd_valid_s1 && (!busy_q || (out_load && ser_last));
	assign s_tready   = !cmd_valid_s1 || frame_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_limit_q   <= TORQUE_FULL;
			brake_limit_q    <= 16'hFFFF;
			throttle_limit_q <= THROTTLE_FULL;
			autonomy_mask_q  <= 4'hF;
			belt_steering_q  <= 1'b0;
			steer_allowed_q  <= 1'b1;
			engine_allowed_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TORQUE_LIMIT:   torque_limit_q   <= cfg_data[14:0];
				REG_BRAKE_LIMIT:    brake_limit_q    <= cfg_data[15:0];
				REG_THROTTLE_LIMIT: throttle_limit_q <= cfg_data[9:0];
				REG_AUTONOMY_MASK:  autonomy_mask_q  <= cfg_data[3:0];
				REG_BELT_STEERING:  belt_steering_q  <= cfg_data[0];
				REG_STEER_ALLOWED:  steer_allowed_q  <= cfg_data[0];
				REG_ENGINE_ALLOWED: engine_allowed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			cmd_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.req_type       <= s_tuser;
			cmd_s1.steer_torque   <= s_tdata[15:0];
			cmd_s1.brake_value    <= s_tdata[31:16];
			cmd_s1.throttle_value <= s_tdata[41:32];
			cmd_s1.gear_code      <= s_tdata[43:42];
			cmd_s1.blinker        <= s_tdata[45:44];
			cmd_s1.kill_req       <= s_tdata[46];
			cmd_s1.horn           <= s_tdata[47];
			cmd_s1.park_brake     <= s_tdata[48];
		end
	end

	// frame build
	logic [14:0]        tl;
	logic [9:0]         thl;
	logic signed [16:0] t_cand, t_lim;
	logic signed [15:0] t_new;
	logic [15:0]        b_cand, b_new;
	logic [9:0]         th_cand, th_new;
	logic [10:0]        tv;
	logic [7:0]         gear_char;
	logic               is_err;
	logic [14:0]        seq_inc;
	frame_t             frame_d;

	always_comb begin
		tl  = (torque_limit_q > TORQUE_FULL) ? TORQUE_FULL : torque_limit_q;
		thl = (throttle_limit_q > THROTTLE_FULL) ? THROTTLE_FULL : throttle_limit_q;

		t_cand = steer_allowed_q ? 17'(cmd_s1.steer_torque) : 17'(held_torque_q);
		t_lim  = signed'({2'b00, tl});
		if (t_cand > t_lim) begin
			t_new = t_lim[15:0];
		end else if (t_cand < -t_lim) begin
			t_new = 16'(-t_lim);
		end else begin
			t_new = t_cand[15:0];
		end

		b_cand  = engine_allowed_q ? cmd_s1.brake_value : held_brake_q;
		b_new   = (b_cand > brake_limit_q) ? brake_limit_q : b_cand;
		th_cand = engine_allowed_q ? cmd_s1.throttle_value : held_throttle_q;
		th_new  = (th_cand > thl) ? thl : th_cand;
		tv      = THROTTLE_BASE + {1'b0, th_new};

		unique case (gear_t'(cmd_s1.gear_code))
			GEAR_FWD: gear_char = GEAR_CHAR_D;
			GEAR_REV: gear_char = GEAR_CHAR_R;
			default:  gear_char = GEAR_CHAR_N;
		endcase

		is_err  = !cmd_s1.req_type && (gear_t'(cmd_s1.gear_code) == GEAR_ILLEGAL);
		seq_inc = seq_q + 15'd1;

		frame_d[0]  = SYNC0;
		frame_d[1]  = SYNC1;
		frame_d[2]  = FRAME_SIZE;
		frame_d[3]  = seq_q[7:0];
		frame_d[4]  = {1'b0, seq_q[14:8]};
		frame_d[5]  = cmd_s1.req_type ? TYPE_EXT : TYPE_DRIVE;
		frame_d[6]  = TYPE_SUFFIX;
		frame_d[15] = TAIL0;
		frame_d[16] = TAIL1;
		if (cmd_s1.req_type) begin
			frame_d[7]  = {3'b000, cmd_s1.park_brake, cmd_s1.horn, cmd_s1.kill_req,
				cmd_s1.blinker[1], cmd_s1.blinker[0]};
			frame_d[8]  = 8'h00;
			frame_d[9]  = 8'h00;
			frame_d[10] = 8'h00;
			frame_d[11] = 8'h00;
			frame_d[12] = 8'h00;
			frame_d[13] = 8'h00;
			frame_d[14] = EXT_FLAGS;
		end else begin
			frame_d[7]  = t_new[7:0];
			frame_d[8]  = t_new[15:8];
			frame_d[9]  = b_new[7:0];
			frame_d[10] = b_new[15:8];
			frame_d[11] = tv[7:0];
			frame_d[12] = {5'b00000, tv[10:8]};
			frame_d[13] = gear_char;
			frame_d[14] = {1'b0, belt_steering_q ? 2'b11 : 2'b10, 1'b0, autonomy_mask_q};
		end
	end

	// held values and sequence counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q           <= '0;
			held_torque_q   <= '0;
			held_brake_q    <= '0;
			held_throttle_q <= '0;
		end else if (frame_load) begin
			if (!cmd_s1.req_type) begin
				held_torque_q   <= t_new;
				held_brake_q    <= b_new;
				held_throttle_q <= th_new;
			end
			if (!is_err) begin
				seq_q <= (seq_inc > SEQ_WRAP) ? '0 : seq_inc;
			end
		end
	end

	// byte serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (frame_load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_load) begin
			busy_q <= !ser_last;
			idx_q  <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (frame_load) begin
			frame_q <= frame_d;
			err_q   <= is_err;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= err_q ? 8'h00 : frame_q[idx_q];
			out_last_q <= ser_last;
			out_err_q  <= err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

	// checks
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("error item without last mark");

	a_tail_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && !m_tuser |-> m_tdata == TAIL1)
		else $error("frame does not end in tail byte");

	a_seq_range: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q <= SEQ_WRAP)
		else $error("sequence counter out of range");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		frame_load |-> !busy_q || ser_last)
		else $error("frame loaded over a running frame");

endmodule

FILE: sim/actuator_command_framer_test.sv
// ----------------------------------------------------------------------------
// actuator_command_framer_test
// Self-checking testbench for the actuator command framer.
// ----------------------------------------------------------------------------
// A short table of directed commands and register writes comes first. A few
// of its rows carry their frames typed in, and the rest are checked against
// a predictor that keeps its own copy of the sequence counter, the held
// values and the registers. Random phases follow, each with its own register
// setting and, bar one, random gaps on both sides. One phase holds the output
// off for a long stretch; another pauses input until the output has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module actuator_command_framer_test;
	import acf_pkg::*;

	localparam int FRAME_BITS  = FRAME_LEN * 8;
	localparam int SCRIPT_ROWS = 28;
	localparam int PHASES      = 6;
	localparam int PHASE_CMDS  = 36;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;

	typedef enum logic [1:0] {
		DO_PREDICT,
		DO_FRAME,
		DO_ERROR,
		DO_CONFIG
	} row_op_t;

	typedef struct packed {
		row_op_t               op;
		cmd_t                  cmd;
		cfg_reg_t              cfg_sel;
		logic [15:0]           value;
		logic [FRAME_BITS-1:0] frame;
	} script_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} out_item_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	// predictor copy of the registers and state
	logic [14:0] lim_torque   = TORQUE_FULL;
	logic [15:0] lim_brake    = 16'hFFFF;
	logic [9:0]  lim_throttle = THROTTLE_FULL;
	logic [3:0]  auto_mask    = 4'hF;
	logic        belt_mode    = 1'b0;
	logic        steer_ok     = 1'b1;
	logic        engine_ok    = 1'b1;
	logic [14:0] seq_no       = '0;
	int          held_torque  = 0;
	logic [15:0] held_brake   = '0;
	logic [9:0]  held_throttle = '0;

	out_item_t   pending_bytes[$];
	script_row_t script [SCRIPT_ROWS];
	int          err_count = 0;
	bit          hold_req  = 1'b0;
	bit          no_gaps   = 1'b0;

	actuator_command_framer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_error(input string what);
		err_count++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	function automatic void predict_frame(input cmd_t c, input bit record);
		logic [7:0]  fr [FRAME_LEN];
		int          tq_max;
		logic [9:0]  thr_max;
		logic [15:0] tq_bits;
		logic [10:0] thr_word;
		int          k;
		for (k = 0; k < FRAME_LEN; k++) fr[k] = 8'h00;
		if (!c.req_type) begin
			tq_max = (lim_torque > TORQUE_FULL) ? int'(TORQUE_FULL) : int'(lim_torque);
			thr_max = (lim_throttle > THROTTLE_FULL) ? THROTTLE_FULL : lim_throttle;
			if (steer_ok) held_torque = int'($signed(c.steer_torque));
			if (engine_ok) begin
				held_brake = c.brake_value;
				held_throttle = c.throttle_value;
			end
			if (held_throttle > thr_max) held_throttle = thr_max;
			if (held_brake > lim_brake) held_brake = lim_brake;
			if (held_torque > tq_max) held_torque = tq_max;
			if (held_torque < -tq_max) held_torque = -tq_max;
			if (c.gear_code == GEAR_ILLEGAL) begin
				if (record) pending_bytes.push_back('{8'h00, 1'b1, 1'b1});
				return;
			end
			tq_bits = held_torque[15:0];
			thr_word = THROTTLE_BASE + {1'b0, held_throttle};
			fr[5] = TYPE_DRIVE;
			fr[7] = tq_bits[7:0];
			fr[8] = tq_bits[15:8];
			fr[9] = held_brake[7:0];
			fr[10] = held_brake[15:8];
			fr[11] = thr_word[7:0];
			fr[12] = {5'b00000, thr_word[10:8]};
			case (c.gear_code)
			GEAR_FWD: fr[13] = GEAR_CHAR_D;
			GEAR_REV: fr[13] = GEAR_CHAR_R;
			default: fr[13] = GEAR_CHAR_N;
			endcase
			fr[14] = {1'b0, belt_mode ? 2'b11 : 2'b10, 1'b0, auto_mask};
		end else begin
			fr[5] = TYPE_EXT;
			fr[7] = {3'b000, c.park_brake, c.horn, c.kill_req, c.blinker};
			fr[14] = EXT_FLAGS;
		end
		fr[0] = SYNC0;
		fr[1] = SYNC1;
		fr[2] = FRAME_SIZE;
		fr[3] = seq_no[7:0];
		fr[4] = {1'b0, seq_no[14:8]};
		fr[6] = TYPE_SUFFIX;
		fr[15] = TAIL0;
		fr[16] = TAIL1;
		if (record) begin
			for (k = 0; k < FRAME_LEN; k++)
				pending_bytes.push_back('{fr[k], k == FRAME_LEN - 1, 1'b0});
		end
		seq_no = seq_no + 15'd1;
		if (seq_no > SEQ_WRAP) seq_no = '0;
	endfunction

	function automatic script_row_t drive_row(input row_op_t op, input logic [15:0] steer,
			input logic [15:0] brake, input logic [9:0] thr, input gear_t gear,
			input logic [FRAME_BITS-1:0] frame);
		script_row_t r;
		r = '0;
		r.op = op;
		r.cmd.steer_torque = steer;
		r.cmd.brake_value = brake;
		r.cmd.throttle_value = thr;
		r.cmd.gear_code = gear;
		r.frame = frame;
		return r;
	endfunction

	// drive fields are filled with junk that an extended frame must ignore
	function automatic script_row_t ext_row(input row_op_t op, input logic [1:0] sig,
			input logic kill, input logic horn, input logic park,
			input logic [FRAME_BITS-1:0] frame);
		script_row_t r;
		r = drive_row(op, 16'h7FFF, 16'hFFFF, 10'h3FF, GEAR_ILLEGAL, frame);
		r.cmd.req_type = 1'b1;
		r.cmd.blinker = sig;
		r.cmd.kill_req = kill;
		r.cmd.horn = horn;
		r.cmd.park_brake = park;
		return r;
	endfunction

	function automatic script_row_t cfg_row(input cfg_reg_t sel, input logic [15:0] val);
		script_row_t r;
		r = '0;
		r.op = DO_CONFIG;
		r.cfg_sel = sel;
		r.value = val;
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(1, 3);
		if (r < 92) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// mode 0 top of range, mode 1 zero, otherwise random with extremes favored
	function automatic logic [15:0] reg_setting(input cfg_reg_t sel, input int mode);
		logic [15:0] top;
		logic [15:0] full;
		case (sel)
		REG_TORQUE_LIMIT: begin
			top = 16'(TORQUE_FULL);
			full = 16'h7FFF;
		end
		REG_BRAKE_LIMIT: begin
			top = 16'hFFFF;
			full = 16'hFFFF;
		end
		REG_THROTTLE_LIMIT: begin
			top = 16'(THROTTLE_FULL);
			full = 16'h03FF;
		end
		REG_AUTONOMY_MASK: begin
			top = 16'h000F;
			full = 16'h000F;
		end
		default: begin
			top = 16'h0001;
			full = 16'h0001;
		end
		endcase
		if (mode == 0) return top;
		if (mode == 1) return 16'h0000;
		case ($urandom_range(0, 3))
		0: return 16'h0000;
		1: return top;
		default: return 16'($urandom_range(0, full));
		endcase
	endfunction

	function automatic cmd_t random_cmd(input bit legal_only);
		cmd_t c;
		int   v;
		c.req_type = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 7))
		0: c.steer_torque = 16'h8000;
		1: c.steer_torque = 16'h7FFF;
		2, 3: begin
			v = int'(lim_torque) + int'($urandom_range(0, 4)) - 2;
			if ($urandom_range(0, 1)) v = -v;
			c.steer_torque = v[15:0];
		end
		default: c.steer_torque = 16'($urandom);
		endcase
		if ($urandom_range(0, 3) == 0)
			c.brake_value = lim_brake + 16'($urandom_range(0, 4)) - 16'd2;
		else
			c.brake_value = 16'($urandom);
		if ($urandom_range(0, 3) == 0)
			c.throttle_value = lim_throttle + 10'($urandom_range(0, 4)) - 10'd2;
		else
			c.throttle_value = 10'($urandom_range(0, 1023));
		if (!legal_only && $urandom_range(0, 7) == 0)
			c.gear_code = GEAR_ILLEGAL;
		else
			c.gear_code = 2'($urandom_range(0, 2));
		c.blinker = 2'($urandom_range(0, 3));
		c.kill_req = 1'($urandom_range(0, 1));
		c.horn = 1'($urandom_range(0, 1));
		c.park_brake = 1'($urandom_range(0, 1));
		return c;
	endfunction

	task automatic send_cmd(input cmd_t c, input row_op_t op,
			input logic [FRAME_BITS-1:0] frame);
		int gap;
		int k;
		s_tvalid <= 1'b1;
		s_tuser <= c.req_type;
		s_tdata <= {7'b0000000, c.park_brake, c.horn, c.kill_req, c.blinker,
			c.gear_code, c.throttle_value, c.brake_value, c.steer_torque};
		do @(posedge clk); while (!s_tready);
		predict_frame(c, op == DO_PREDICT);
		if (op == DO_ERROR) pending_bytes.push_back('{8'h00, 1'b1, 1'b1});
		if (op == DO_FRAME) begin
			for (k = 0; k < FRAME_LEN; k++)
				pending_bytes.push_back('{frame[(FRAME_LEN - 1 - k) * 8 +: 8],
					k == FRAME_LEN - 1, 1'b0});
		end
		gap = (no_gaps || $urandom_range(0, 1)) ? 0 : gap_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_frames();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
		REG_TORQUE_LIMIT: lim_torque = val[14:0];
		REG_BRAKE_LIMIT: lim_brake = val;
		REG_THROTTLE_LIMIT: lim_throttle = val[9:0];
		REG_AUTONOMY_MASK: auto_mask = val[3:0];
		REG_BELT_STEERING: belt_mode = val[0];
		REG_STEER_ALLOWED: steer_ok = val[0];
		REG_ENGINE_ALLOWED: engine_ok = val[0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	always @(posedge clk) begin : check_output
		out_item_t want;
		if (m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				flag_error($sformatf("unexpected item %h last %b err %b",
					m_tdata, m_tlast, m_tuser));
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata !== want.data)
					flag_error($sformatf("byte %h, want %h", m_tdata, want.data));
				if (m_tlast !== want.last)
					flag_error($sformatf("last %b, want %b", m_tlast, want.last));
				if (m_tuser !== want.err)
					flag_error($sformatf("gear error %b, want %b", m_tuser, want.err));
			end
		end
	end

	initial begin : receiver
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (no_gaps || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		script_row_t row;
		cfg_reg_t    sel;
		int          i;
		int          p;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;

		script = '{
			drive_row(DO_FRAME, 16'h0000, 16'h0000, 10'd0, GEAR_FWD,
				136'hAA_55_0A_00_00_E0_06_00_00_00_00_C8_00_44_4F_BB_66),
			ext_row(DO_FRAME, 2'd3, 1'b1, 1'b1, 1'b1,
				136'hAA_55_0A_01_00_E1_06_1F_00_00_00_00_00_00_09_BB_66),
			drive_row(DO_ERROR, 16'd1234, 16'd77, 10'd5, GEAR_ILLEGAL, '0),
			drive_row(DO_FRAME, 16'h7FFF, 16'hFFFF, 10'h3FF, GEAR_REV,
				136'hAA_55_0A_02_00_E0_06_F8_7F_FF_FF_20_03_52_4F_BB_66),
			drive_row(DO_FRAME, 16'h8000, 16'h0000, 10'd0, GEAR_NTRL,
				136'hAA_55_0A_03_00_E0_06_08_80_00_00_C8_00_4E_4F_BB_66),
			ext_row(DO_PREDICT, 2'd1, 1'b0, 1'b0, 1'b0, '0),
			ext_row(DO_PREDICT, 2'd2, 1'b0, 1'b1, 1'b0, '0),
			ext_row(DO_PREDICT, 2'd0, 1'b1, 1'b0, 1'b1, '0),
			drive_row(DO_PREDICT, 16'd100, 16'd200, 10'd600, GEAR_FWD, '0),
			cfg_row(REG_TORQUE_LIMIT, 16'h0000),
			cfg_row(REG_BRAKE_LIMIT, 16'h0000),
			cfg_row(REG_THROTTLE_LIMIT, 16'h0000),
			cfg_row(REG_AUTONOMY_MASK, 16'h0000),
			cfg_row(REG_BELT_STEERING, 16'h0001),
			drive_row(DO_PREDICT, 16'hFFFB, 16'd100, 10'd50, GEAR_REV, '0),
			cfg_row(REG_TORQUE_LIMIT, 16'h7FFF),
			cfg_row(REG_THROTTLE_LIMIT, 16'h03FF),
			cfg_row(REG_BRAKE_LIMIT, 16'hFFFF),
			cfg_row(REG_AUTONOMY_MASK, 16'h000A),
			drive_row(DO_PREDICT, 16'h8000, 16'd1, 10'h3FF, GEAR_NTRL, '0),
			cfg_row(REG_STEER_ALLOWED, 16'h0000),
			cfg_row(REG_ENGINE_ALLOWED, 16'h0000),
			drive_row(DO_PREDICT, 16'd500, 16'd900, 10'd10, GEAR_FWD, '0),
			cfg_row(REG_TORQUE_LIMIT, 16'd100),
			drive_row(DO_ERROR, 16'd7, 16'd7, 10'd7, GEAR_ILLEGAL, '0),
			drive_row(DO_PREDICT, 16'd7, 16'd7, 10'd7, GEAR_REV, '0),
			cfg_row(REG_STEER_ALLOWED, 16'h0001),
			cfg_row(REG_ENGINE_ALLOWED, 16'h0001)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < SCRIPT_ROWS; i++) begin
			row = script[i];
			if (row.op == DO_CONFIG) begin
				drain_frames();
				write_reg(row.cfg_sel, row.value);
			end else begin
				send_cmd(row.cmd, row.op, row.frame);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			drain_frames();
			sel = REG_TORQUE_LIMIT;
			repeat (sel.num()) begin
				write_reg(sel, reg_setting(sel, p));
				sel = sel.next();
			end
			no_gaps = (p == 4);
			for (i = 0; i < PHASE_CMDS; i++) begin
				// output held off while commands keep coming
				if (p == 2 && i == 10) hold_req = 1'b1;
				// input paused until the output has caught up
				if (p == 3 && i == 18) drain_frames();
				send_cmd(random_cmd(1'b0), DO_PREDICT, '0);
			end
		end

		drain_frames();
		repeat (2 * FRAME_LEN) @(posedge clk);
		if (pending_bytes.size() != 0) flag_error("items missing at end of run");
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/acf_pkg.sv
hdl/actuator_command_framer.sv
sim/actuator_command_framer_test.sv
